@@ rtl/core/hfsz_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and rounding helper for the half-float scale and zero-point converter.
package hfsz_pkg;

  typedef enum logic [1:0] {
    MODE_F32_F16  = 2'd0,
    MODE_F16_F32  = 2'd1,
    MODE_BF16_F16 = 2'd2,
    MODE_F16_BF16 = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE      = 2'd0,
    REG_SCALE     = 2'd1,
    REG_INV_SCALE = 2'd2,
    REG_ZP_OFFSET = 2'd3
  } reg_idx_t;

  localparam int ADDR_W     = 4;
  localparam int NUM_STAGES = 11;

  localparam logic [31:0] F32_ONE         = 32'h3F80_0000;
  localparam logic [31:0] F32_DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] F32_QUIET_BIT   = 32'h0040_0000;
  localparam logic [31:0] BF16_ROUND_BIAS = 32'h0000_7FFF;

  // Per-unit pipeline control: one enable per internal stage and a bypass request.
  typedef struct packed {
    logic [2:0] en;
    logic       bypass;
  } fpu_ctl_t;

  // Sideband that travels with each item.
  typedef struct packed {
    mode_t mode;
    logic  last;
    logic  scaling;
  } side_t;

  // Round to nearest even and pack an f32; e is the biased exponent of the
  // mantissa window (1 for subnormals), overflow gives infinity.
  function automatic logic [31:0] round_pack(input logic sign, input logic [9:0] e,
                                             input logic [23:0] mant, input logic g,
                                             input logic st);
    logic        up;
    logic [24:0] m25;
    logic [9:0]  ef;
    logic        hid;
    logic [22:0] frac;
    up  = g & (st | mant[0]);
    m25 = {1'b0, mant} + {24'd0, up};
    if (m25[24]) begin
      ef   = e + 10'd1;
      hid  = 1'b1;
      frac = m25[23:1];
    end else begin
      ef   = e;
      hid  = m25[23];
      frac = m25[22:0];
    end
    if (ef >= 10'd255) begin
      return {sign, 8'hFF, 23'd0};
    end
    return {sign, hid ? ef[7:0] : 8'd0, frac};
  endfunction

endpackage

@@ rtl/core/hfsz_in_if.sv @@
`timescale 1ns / 1ps
// Input item channel: valid/ready handshake with element and last flag.
interface hfsz_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] element_in;
  logic        last_in;

  modport source (output valid, output element_in, output last_in, input ready);
  modport sink (input valid, input element_in, input last_in, output ready);
endinterface

@@ rtl/core/hfsz_out_if.sv @@
`timescale 1ns / 1ps
// Result item channel: valid/ready handshake with element and last flag.
interface hfsz_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] element_out;
  logic        last_out;

  modport source (output valid, output element_out, output last_out, input ready);
  modport sink (input valid, input element_out, input last_out, output ready);
endinterface

@@ rtl/core/half_float_scale_zero_point_converter.sv @@
`timescale 1ns / 1ps
// Top level of the half-float scale and zero-point converter.
//
//   Port group   Direction  Handshake            Carries
//   in_ch        sink       valid/ready          element_in, last_in
//   out_ch       source     valid/ready          element_out, last_out
//   APB port     slave      psel/penable/pready  mode, scale, inv_scale, zp offset
//
// One item is accepted per cycle unless a stall on out_ch backs up to the input;
// the depth is set by the two three-stage f32 adders and the three-stage f32
// multiplier between the widening and narrowing stages.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults. Each stage holds its item while the stage after it is full and
// stalled, so a stall on out_ch backs up stage by stage and bubbles close up.

module half_float_scale_zero_point_converter (
  input  logic                          clk,
  input  logic                          rst_n,
  hfsz_in_if.sink                       in_ch,
  hfsz_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hfsz_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import hfsz_pkg::*;

  // f16 bit pattern widened to f32; NaN payloads move to the top of the fraction.
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  n;
    logic [10:0] mm;
    logic [7:0]  ex;
    logic [7:0]  en;
    e  = h[14:10];
    m  = h[9:0];
    n  = 4'd9;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) n = 4'(9 - i);
    end
    mm = {1'b0, m} << (n + 4'd1);
    ex = 8'd112 - {4'd0, n};
    en = {3'd0, e} + 8'd112;
    if (e == 5'h1F) begin
      return (m == 10'd0) ? {h[15], 31'h7F80_0000}
                          : {h[15], 8'hFF, 1'b1, m[8:0], 13'd0} | {9'd0, m[9], 22'd0};
    end
    if (e == 5'd0) begin
      return (m == 10'd0) ? {h[15], 31'd0} : {h[15], ex, mm[9:0], 13'd0};
    end
    return {h[15], en, m, 13'd0};
  endfunction

  // Signed integer to f32, round to nearest even.
  function automatic logic [31:0] int_to_single(input logic [31:0] z);
    logic [31:0] mag;
    logic [5:0]  lz;
    logic [31:0] norm;
    logic        up;
    logic [24:0] m25;
    logic [7:0]  ex;
    mag = z[31] ? (~z + 32'd1) : z;
    lz  = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) lz = 6'(31 - i);
    end
    norm = mag << lz[4:0];
    up   = norm[7] & ((|norm[6:0]) | norm[8]);
    m25  = {1'b0, norm[31:8]} + {24'd0, up};
    ex   = 8'd158 - {2'd0, lz};
    if (mag == 32'd0) begin
      return 32'd0;
    end
    if (m25[24]) begin
      return {z[31], ex + 8'd1, m25[23:1]};
    end
    return {z[31], ex, m25[22:0]};
  endfunction

  // Configuration registers. The zero point is also kept as an f32, registered
  // from the integer register; items read it no earlier than that update.
  mode_t       mode_r;
  logic [31:0] scale_r, inv_scale_r, zp_r, zpf_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_F32_F16;
      scale_r     <= F32_ONE;
      inv_scale_r <= F32_ONE;
      zp_r        <= 32'd0;
      zpf_r       <= 32'd0;
    end else begin
      zpf_r <= int_to_single(zp_r);
      if (cfg_wr) begin
        case (cfg_idx)
          REG_MODE:      mode_r      <= mode_t'(pwdata[1:0]);
          REG_SCALE:     scale_r     <= pwdata;
          REG_INV_SCALE: inv_scale_r <= pwdata;
          REG_ZP_OFFSET: zp_r        <= pwdata;
          default:       mode_r      <= mode_r;
        endcase
      end
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MODE:      prdata = {30'd0, mode_r};
      REG_SCALE:     prdata = scale_r;
      REG_INV_SCALE: prdata = inv_scale_r;
      REG_ZP_OFFSET: prdata = zp_r;
      default:       prdata = 32'd0;
    endcase
  end

  // Pipeline control: a stage may load when it is empty or its successor loads.
  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES:0]   rdy;
  side_t                 side_r [NUM_STAGES];
  side_t                 side0;

  always_comb begin
    rdy[NUM_STAGES] = out_ch.ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  assign in_ch.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (rdy[0]) valid_r[0] <= in_ch.valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) valid_r[k] <= valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) side_r[0] <= side0;
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (rdy[k]) side_r[k] <= side_r[k-1];
    end
  end

  // Stage 0: widen the source to f32 and decide whether scaling applies.
  // Only the exact pattern of 1.0 compares equal to one, so a NaN scale
  // turns scaling on.
  logic [31:0] widened;
  logic [31:0] v0_r;

  always_comb begin
    case (mode_r)
      MODE_F32_F16:  widened = in_ch.element_in;
      MODE_BF16_F16: widened = {in_ch.element_in[15:0], 16'd0};
      default:       widened = half_to_single(in_ch.element_in[15:0]);
    endcase
    side0.mode    = mode_r;
    side0.last    = in_ch.last_in;
    side0.scaling = (scale_r != F32_ONE) || (zp_r != 32'd0);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) v0_r <= widened;
  end

  // Stages 1-3: x - zp for the dequantizing modes, passed through otherwise.
  // Stages 4-6: product with scale or inv_scale.
  // Stages 7-9: + zp for the quantizing modes, passed through otherwise.
  fpu_ctl_t    ctl_a, ctl_m, ctl_b;
  logic [31:0] neg_zpf, mul_b, a_y, m_y, b_y;
  logic        deq_a, quant_m, quant_b;

  assign deq_a   = (side_r[0].mode == MODE_F16_F32) || (side_r[0].mode == MODE_F16_BF16);
  assign quant_m = (side_r[3].mode == MODE_F32_F16) || (side_r[3].mode == MODE_BF16_F16);
  assign quant_b = (side_r[6].mode == MODE_F32_F16) || (side_r[6].mode == MODE_BF16_F16);

  assign neg_zpf      = {~zpf_r[31], zpf_r[30:0]};
  assign mul_b        = quant_m ? inv_scale_r : scale_r;
  assign ctl_a.en     = rdy[3:1];
  assign ctl_a.bypass = !(side_r[0].scaling && deq_a);
  assign ctl_m.en     = rdy[6:4];
  assign ctl_m.bypass = !side_r[3].scaling;
  assign ctl_b.en     = rdy[9:7];
  assign ctl_b.bypass = !(side_r[6].scaling && quant_b);

  hfsz_fadd u_sub_zp (
    .clk (clk),
    .ctl (ctl_a),
    .a   (v0_r),
    .b   (neg_zpf),
    .y   (a_y)
  );

  hfsz_fmul u_mul_scale (
    .clk (clk),
    .ctl (ctl_m),
    .a   (a_y),
    .b   (mul_b),
    .y   (m_y)
  );

  hfsz_fadd u_add_zp (
    .clk (clk),
    .ctl (ctl_b),
    .a   (m_y),
    .b   (zpf_r),
    .y   (b_y)
  );

  // Stage 10: narrow to the destination format; this is the output register.
  hfsz_narrow u_narrow (
    .clk     (clk),
    .en      (rdy[10]),
    .mode    (side_r[9].mode),
    .v       (b_y),
    .element (out_ch.element_out)
  );

  assign out_ch.valid    = valid_r[NUM_STAGES-1];
  assign out_ch.last_out = side_r[NUM_STAGES-1].last;

  // A full pipeline facing a stalled sink must not take another item.
  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    ((&valid_r) && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while pipeline full and stalled");

  // The first stage keeps its item while the next stage cannot load.
  a_first_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[0] && !rdy[1]) |=> valid_r[0])
    else $error("first stage dropped an item under stall");

  // An accepted item always lands in the first stage.
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> valid_r[0])
    else $error("accepted item not captured");

  // A zero integer zero point converts to a positive zero.
  a_zp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (zp_r == 32'd0) |=> (zpf_r == 32'd0))
    else $error("zero point conversion wrong for zero");

endmodule

@@ rtl/core/hfsz_fadd.sv @@
`timescale 1ns / 1ps
// Three-stage IEEE f32 adder with round to nearest even and subnormal support.
module hfsz_fadd (
  input  logic               clk,
  input  hfsz_pkg::fpu_ctl_t ctl,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  output logic [31:0]        y
);
  import hfsz_pkg::*;

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    n = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) n = 5'(26 - i);
    end
    return n;
  endfunction

  // Stage 1: classify, order by magnitude and align.
  logic        a_nan, b_nan, a_inf, b_inf, swap, spec, sub;
  logic [31:0] big, sml, spec_val;
  logic [7:0]  e_big, e_sml, d;
  logic [23:0] m_big, m_sml;
  logic [4:0]  dd;
  logic [50:0] sh;

  logic        s1_spec_r, s1_sign_r, s1_sub_r;
  logic [31:0] s1_spec_val_r;
  logic [7:0]  s1_exp_r;
  logic [26:0] s1_big_r, s1_sml_r;

  always_comb begin
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    spec     = 1'b1;
    spec_val = a;
    if (ctl.bypass) begin
      spec_val = a;
    end else if (a_nan) begin
      spec_val = a | F32_QUIET_BIT;
    end else if (b_nan) begin
      spec_val = b | F32_QUIET_BIT;
    end else if (a_inf && b_inf && (a[31] != b[31])) begin
      spec_val = F32_DEFAULT_NAN;
    end else if (a_inf) begin
      spec_val = a;
    end else if (b_inf) begin
      spec_val = b;
    end else begin
      spec = 1'b0;
    end
    swap  = b[30:0] > a[30:0];
    big   = swap ? b : a;
    sml   = swap ? a : b;
    e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    m_big = {big[30:23] != 8'd0, big[22:0]};
    m_sml = {sml[30:23] != 8'd0, sml[22:0]};
    d     = e_big - e_sml;
    dd    = (d > 8'd27) ? 5'd27 : d[4:0];
    sh    = {m_sml, 27'd0} >> dd;
    sub   = big[31] ^ sml[31];
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      s1_spec_r     <= spec;
      s1_spec_val_r <= spec_val;
      s1_sign_r     <= big[31];
      s1_sub_r      <= sub;
      s1_exp_r      <= e_big;
      s1_big_r      <= {m_big, 3'b000};
      s1_sml_r      <= {sh[50:25], sh[24] | (|sh[23:0])};
    end
  end

  // Stage 2: add or subtract, find the normalizing shift.
  logic [27:0] sum;
  logic [26:0] m27;
  logic [4:0]  lz, lsh;
  logic [7:0]  emax;
  logic [8:0]  e9;

  logic        s2_spec_r, s2_sign_r, s2_sub_r, s2_zero_r;
  logic [31:0] s2_spec_val_r;
  logic [8:0]  s2_e_r;
  logic [26:0] s2_m_r;
  logic [4:0]  s2_lsh_r;

  always_comb begin
    sum  = s1_sub_r ? ({1'b0, s1_big_r} - {1'b0, s1_sml_r})
                    : ({1'b0, s1_big_r} + {1'b0, s1_sml_r});
    lz   = lzc27(sum[26:0]);
    emax = s1_exp_r - 8'd1;
    if (sum[27]) begin
      m27 = {sum[27:2], sum[1] | sum[0]};
      lsh = 5'd0;
      e9  = {1'b0, s1_exp_r} + 9'd1;
    end else begin
      m27 = sum[26:0];
      lsh = ({3'd0, lz} <= emax) ? lz : emax[4:0];
      e9  = {1'b0, s1_exp_r} - {4'd0, lsh};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      s2_spec_r     <= s1_spec_r;
      s2_spec_val_r <= s1_spec_val_r;
      s2_sign_r     <= s1_sign_r;
      s2_sub_r      <= s1_sub_r;
      s2_zero_r     <= (sum == 28'd0);
      s2_e_r        <= e9;
      s2_m_r        <= m27;
      s2_lsh_r      <= lsh;
    end
  end

  // Stage 3: normalize and round.
  logic [26:0] mn;
  logic [31:0] y_nxt;
  logic [31:0] y_r;

  always_comb begin
    mn = s2_m_r << s2_lsh_r;
    if (s2_spec_r) begin
      y_nxt = s2_spec_val_r;
    end else if (s2_zero_r) begin
      // Exact cancellation gives +0; zeros of the same sign keep it.
      y_nxt = {s2_sign_r & ~s2_sub_r, 31'd0};
    end else begin
      y_nxt = round_pack(s2_sign_r, {1'b0, s2_e_r}, mn[26:3], mn[2], mn[1] | mn[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      y_r <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

@@ rtl/core/hfsz_fmul.sv @@
`timescale 1ns / 1ps
// Three-stage IEEE f32 multiplier with round to nearest even and subnormal support.
module hfsz_fmul (
  input  logic               clk,
  input  hfsz_pkg::fpu_ctl_t ctl,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  output logic [31:0]        y
);
  import hfsz_pkg::*;

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  // Stage 1: classify and multiply the significands.
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sign, spec;
  logic [31:0] spec_val;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;

  logic        s1_spec_r, s1_sign_r;
  logic [31:0] s1_spec_val_r;
  logic [47:0] s1_prod_r;
  logic [10:0] s1_e_r;

  always_comb begin
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    sign   = a[31] ^ b[31];
    spec     = 1'b1;
    spec_val = a;
    if (ctl.bypass) begin
      spec_val = a;
    end else if (a_nan) begin
      spec_val = a | F32_QUIET_BIT;
    end else if (b_nan) begin
      spec_val = b | F32_QUIET_BIT;
    end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
      spec_val = F32_DEFAULT_NAN;
    end else if (a_inf || b_inf) begin
      spec_val = {sign, 8'hFF, 23'd0};
    end else if (a_zero || b_zero) begin
      spec_val = {sign, 31'd0};
    end else begin
      spec = 1'b0;
    end
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      s1_spec_r     <= spec;
      s1_spec_val_r <= spec_val;
      s1_sign_r     <= sign;
      s1_prod_r     <= ma * mb;
      s1_e_r        <= {3'd0, ea} + {3'd0, eb} - 11'd126;
    end
  end

  // Stage 2: normalize the product so its leading one sits at the top.
  logic [5:0] lz;

  logic        s2_spec_r, s2_sign_r;
  logic [31:0] s2_spec_val_r;
  logic [47:0] s2_p_r;
  logic [10:0] s2_e_r;

  assign lz = lzc48(s1_prod_r);

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      s2_spec_r     <= s1_spec_r;
      s2_spec_val_r <= s1_spec_val_r;
      s2_sign_r     <= s1_sign_r;
      s2_p_r        <= s1_prod_r << lz;
      s2_e_r        <= s1_e_r - {5'd0, lz};
    end
  end

  // Stage 3: denormalize tiny results, then round.
  logic        nonpos;
  logic [10:0] rs;
  logic [5:0]  rsc;
  logic [95:0] w;
  logic [9:0]  e;
  logic [31:0] y_nxt;
  logic [31:0] y_r;

  always_comb begin
    nonpos = s2_e_r[10] || (s2_e_r == 11'd0);
    rs     = 11'd1 - s2_e_r;
    rsc    = nonpos ? ((rs > 11'd48) ? 6'd48 : rs[5:0]) : 6'd0;
    w      = {s2_p_r, 48'd0} >> rsc;
    e      = nonpos ? 10'd1 : s2_e_r[9:0];
    if (s2_spec_r) begin
      y_nxt = s2_spec_val_r;
    end else begin
      y_nxt = round_pack(s2_sign_r, e, w[95:72], w[71], |w[70:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      y_r <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

@@ rtl/core/hfsz_narrow.sv @@
`timescale 1ns / 1ps
// Output stage: narrows the f32 result to f16 or bf16 by mode, or passes it on as f32, and registers it.
module hfsz_narrow (
  input  logic            clk,
  input  logic            en,
  input  hfsz_pkg::mode_t mode,
  input  logic [31:0]     v,
  output logic [31:0]     element
);
  import hfsz_pkg::*;

  function automatic logic [15:0] single_to_half(input logic [31:0] x);
    logic [7:0]  e;
    logic [22:0] m;
    logic [9:0]  keep;
    logic [12:0] rem;
    logic [14:0] r;
    logic [7:0]  s;
    logic [47:0] ext;
    logic [23:0] k2;
    logic        up;
    e    = x[30:23];
    m    = x[22:0];
    keep = m[22:13];
    rem  = m[12:0];
    s    = 8'd126 - e;
    ext  = {1'b1, m, 24'd0} >> s[4:0];
    k2   = ext[47:24];
    if (e == 8'hFF) begin
      return (m == 23'd0) ? {x[31], 15'h7C00} : {x[31], 15'h7E00 | {5'd0, m[22:13]}};
    end
    if (e == 8'd0) begin
      return {x[31], 15'd0};
    end
    if (e >= 8'd143) begin
      return {x[31], 15'h7C00};
    end
    if (e >= 8'd113) begin
      up = (rem > 13'h1000) || ((rem == 13'h1000) && keep[0]);
      r  = {5'(e - 8'd112), keep} + {14'd0, up};
      return {x[31], r};
    end
    if (s > 8'd24) begin
      return {x[31], 15'd0};
    end
    up = ext[23] & ((|ext[22:0]) | k2[0]);
    r  = k2[14:0] + {14'd0, up};
    return {x[31], r};
  endfunction

  function automatic logic [15:0] single_to_bf16(input logic [31:0] x);
    logic [31:0] sum;
    sum = x + BF16_ROUND_BIAS + {31'd0, x[16]};
    return sum[31:16];
  endfunction

  logic [31:0] element_nxt;
  logic [31:0] element_r;

  always_comb begin
    case (mode)
      MODE_F16_F32:  element_nxt = v;
      MODE_F16_BF16: element_nxt = {16'd0, single_to_bf16(v)};
      default:       element_nxt = {16'd0, single_to_half(v)};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      element_r <= element_nxt;
    end
  end

  assign element = element_r;

endmodule

@@ tb/hfsz_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the converter: snoops register writes, predicts each item and compares results.
module hfsz_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  hfsz_in_if                            in_ch,
  hfsz_out_if                           out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [hfsz_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output int                            errors,
  output int                            pending
);
  import hfsz_pkg::*;

  typedef struct {
    logic [31:0] elem;
    logic        last;
  } conv_result_t;

  mode_t       cur_mode;
  logic [31:0] cur_scale;
  logic [31:0] cur_inv_scale;
  logic [31:0] cur_zp_offset;

  conv_result_t expected_q[$];

  assign pending = expected_q.size();

  // Exact power of two as a double.
  function automatic real pow2(int n);
    logic [10:0] be;
    be = 11'(n + 1023);
    return $bitstoreal({1'b0, be, 52'd0});
  endfunction

  // Non-NaN f32 pattern to its exact double value.
  function automatic real f32_to_real(logic [31:0] b);
    real r;
    if (b[30:23] == 8'hFF) return $bitstoreal({b[31], 11'h7FF, 52'd0});
    if (b[30:23] == 8'd0) r = real'(b[22:0]) * pow2(-149);
    else r = real'({1'b1, b[22:0]}) * pow2(int'(b[30:23]) - 150);
    return b[31] ? -r : r;
  endfunction

  // Double to f32 with round to nearest even, including subnormals and overflow.
  function automatic logic [31:0] real_to_f32(real r);
    logic [63:0] db;
    logic [63:0] full;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    logic [30:0] base;
    logic [30:0] res;
    logic        up;
    int          ef;
    int          sh;
    db = $realtobits(r);
    if (db[62:52] == 11'h7FF) return {db[63], 8'hFF, 23'd0};
    if (db[62:52] == 11'd0) return {db[63], 31'd0};
    ef = int'(db[62:52]) - 1023 + 127;
    if (ef >= 255) return {db[63], 8'hFF, 23'd0};
    full = {11'd0, 1'b1, db[51:0]};
    sh = (ef >= 1) ? 29 : 30 - ef;
    if (sh > 60) return {db[63], 31'd0};
    keep = full >> sh;
    rem  = full & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    up   = (rem > half) || (rem == half && keep[0]);
    if (ef >= 1) base = {ef[7:0], keep[22:0]};
    else base = keep[30:0];
    res = base + {30'd0, up};
    return {db[63], res};
  endfunction

  function automatic logic is_nan(logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] != 23'd0;
  endfunction

  // The double result of one f32 operation is exact enough that rounding it once more
  // to f32 gives the correctly rounded value. NaN operands propagate quieted, first one
  // first; an invalid operation gives the default NaN.
  function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
    real r;
    if (is_nan(a)) return a | F32_QUIET_BIT;
    if (is_nan(b)) return b | F32_QUIET_BIT;
    r = f32_to_real(a) * f32_to_real(b);
    if (r != r) return F32_DEFAULT_NAN;
    return real_to_f32(r);
  endfunction

  function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
    real r;
    if (is_nan(a)) return a | F32_QUIET_BIT;
    if (is_nan(b)) return b | F32_QUIET_BIT;
    r = f32_to_real(a) + f32_to_real(b);
    if (r != r) return F32_DEFAULT_NAN;
    return real_to_f32(r);
  endfunction

  function automatic logic [31:0] widen_half(logic [15:0] h);
    logic [31:0] sgn;
    logic [9:0]  m;
    int          ex;
    sgn = {h[15], 31'd0};
    m = h[9:0];
    if (h[14:10] == 5'h1F) begin
      if (m == 10'd0) return sgn | 32'h7F80_0000;
      return sgn | 32'h7FC0_0000 | {9'd0, m, 13'd0};
    end
    if (h[14:10] == 5'd0) begin
      if (m == 10'd0) return sgn;
      ex = 113;
      while (!m[9]) begin
        m = m << 1;
        ex--;
      end
      // The leading one now sits in bit 9, one step below the hidden bit.
      return sgn | {1'b0, 8'(ex - 1), m[8:0], 14'd0};
    end
    return sgn | {1'b0, 8'(int'(h[14:10]) + 112), m, 13'd0};
  endfunction

  function automatic logic [15:0] narrow_half(logic [31:0] x);
    logic [15:0] sgn;
    logic [23:0] full;
    logic [23:0] keep;
    logic [23:0] rem;
    logic [23:0] half;
    logic [15:0] r;
    int          e;
    int          sh;
    sgn = {x[31], 15'd0};
    e = int'(x[30:23]);
    if (e == 255) begin
      if (x[22:0] == 23'd0) return sgn | 16'h7C00;
      return sgn | 16'h7E00 | {6'd0, x[22:13]};
    end
    if (e == 0) return sgn;
    if (e >= 143) return sgn | 16'h7C00;
    if (e >= 113) begin
      r = {1'b0, 5'(e - 112), x[22:13]};
      if (x[12:0] > 13'h1000 || (x[12:0] == 13'h1000 && x[13])) r = r + 16'd1;
      return sgn | r;
    end
    sh = 126 - e;
    if (sh > 24) return sgn;
    full = {1'b1, x[22:0]};
    keep = full >> sh;
    rem  = full & ((24'd1 << sh) - 24'd1);
    half = 24'd1 << (sh - 1);
    r = keep[15:0];
    if (rem > half || (rem == half && keep[0])) r = r + 16'd1;
    return sgn | r;
  endfunction

  function automatic logic [15:0] narrow_bf16(logic [31:0] x);
    logic [31:0] rounded;
    rounded = x + BF16_ROUND_BIAS + {31'd0, x[16]};
    return rounded[31:16];
  endfunction

  function automatic logic [31:0] convert_element(logic [31:0] elem);
    logic [31:0] zp_f;
    logic [31:0] v;
    logic        scaling;
    zp_f = real_to_f32(real'($signed(cur_zp_offset)));
    scaling = cur_scale != F32_ONE || cur_zp_offset != 32'd0;
    case (cur_mode)
      MODE_F32_F16, MODE_BF16_F16: begin
        v = (cur_mode == MODE_F32_F16) ? elem : {elem[15:0], 16'd0};
        if (scaling) v = f32_add(f32_mul(v, cur_inv_scale), zp_f);
        return {16'd0, narrow_half(v)};
      end
      default: begin
        v = widen_half(elem[15:0]);
        if (scaling) v = f32_mul(f32_add(v, zp_f ^ 32'h8000_0000), cur_scale);
        if (cur_mode == MODE_F16_F32) return v;
        return {16'd0, narrow_bf16(v)};
      end
    endcase
  endfunction

  always @(posedge clk) begin
    conv_result_t want;
    if (!rst_n) begin
      cur_mode      <= MODE_F32_F16;
      cur_scale     <= F32_ONE;
      cur_inv_scale <= F32_ONE;
      cur_zp_offset <= 32'd0;
      expected_q.delete();
      errors        <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_MODE:      cur_mode <= mode_t'(pwdata[1:0]);
          REG_SCALE:     cur_scale <= pwdata;
          REG_INV_SCALE: cur_inv_scale <= pwdata;
          REG_ZP_OFFSET: cur_zp_offset <= pwdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        want.elem = convert_element(in_ch.element_in);
        want.last = in_ch.last_in;
        expected_q.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("Unexpected result item %h", out_ch.element_out);
          errors <= errors + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.elem !== out_ch.element_out || want.last !== out_ch.last_out) begin
            if (errors < 10)
              $display("Mismatch: expected element %h last %b, got element %h last %b",
                       want.elem, want.last, out_ch.element_out, out_ch.last_out);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Top of the converter testbench: clock, reset, register setup, item stimulus and verdict.
module tb;
  import hfsz_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  int                  errors;
  int                  pending;
  int                  cycles = 0;

  // Percent chances of an idle cycle on each side, changed between phases.
  int                  send_idle_pct = 35;
  int                  recv_idle_pct = 77;
  // Set once to make the receiver refuse results for a long stretch.
  logic                pressure_req = 1'b0;
  logic                stall_hold = 1'b0;

  hfsz_in_if  in_ch ();
  hfsz_out_if out_ch ();

  half_float_scale_zero_point_converter u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  hfsz_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (errors),
    .pending (pending)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.element_in = 32'd0;
    in_ch.last_in    = 1'b0;
    out_ch.ready     = 1'b0;
  end

  // The receiver refuses results at random, or for the whole pressure stretch.
  always @(posedge clk) begin
    if (!rst_n || stall_hold) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // The long hold-off is timed here, apart from the stimulus, so the sender keeps
  // offering items while the pipeline fills and backs up into the input.
  initial begin
    wait (pressure_req);
    @(posedge clk);
    stall_hold <= 1'b1;
    repeat (300) @(posedge clk);
    stall_hold <= 1'b0;
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Setup cycle, then access cycle; the register takes the value at the access edge.
  // psel stays high into the next setup cycle, and the caller ends the transfers.
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  // Registers change only once the pipeline has drained. The input is idled
  // first, and the task waits on the clock so the last accepted item is counted as pending.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (NUM_STAGES + 4) @(posedge clk);
  endtask

  task automatic set_config(mode_t m, logic [31:0] scale, logic [31:0] inv_scale,
                            logic [31:0] zp);
    wait_drained();
    write_reg(REG_MODE, {30'd0, m});
    write_reg(REG_SCALE, scale);
    write_reg(REG_INV_SCALE, inv_scale);
    write_reg(REG_ZP_OFFSET, zp);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Valid stays high from one item to the next unless an idle cycle is drawn.
  task automatic send_item(logic [31:0] elem, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.element_in <= elem;
    in_ch.last_in    <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Random element bits, often pushed toward zero, subnormal, infinity and NaN
  // encodings of the f32, f16 and bf16 layouts.
  function automatic logic [31:0] rand_element();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(7))
      0: v[30:23] = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      1: v[30:23] = 8'($urandom_range(95, 150));
      2: v[14:10] = ($urandom_range(1) != 0) ? 5'h1F : 5'h00;
      3: v[14:7]  = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      4: v[14:10] = 5'($urandom_range(20, 30));
      default: ;
    endcase
    return v;
  endfunction

  logic [31:0] f32_edges[12] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0001,
                                 32'h7FC0_1234, 32'h0000_0001, 32'h477F_F000, 32'h3300_0000,
                                 32'h387F_E000, 32'h7F7F_FFFF, 32'hFFFF_FFFF, 32'h3F80_1000};
  logic [31:0] half_edges[12] = '{32'h0000_0000, 32'hFFFF_8000, 32'h0000_7C00, 32'hABCD_FC00,
                                  32'h0000_7C01, 32'h5555_7E00, 32'h0000_0001, 32'h0000_03FF,
                                  32'h0000_7BFF, 32'hFFFF_FFFF, 32'h0000_0400, 32'h1234_3C00};

  initial begin
    mode_t       m;
    logic [31:0] scale;
    logic [31:0] inv_scale;
    logic [31:0] zp;
    int          flavor;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed edges, unscaled: f32 narrowing, then f16 to bf16 with garbage upper bits.
    foreach (f32_edges[i]) send_item(f32_edges[i], i[0]);
    set_config(MODE_F16_BF16, F32_ONE, F32_ONE, 32'd0);
    foreach (half_edges[i]) send_item(half_edges[i], i[0]);

    // Each phase walks one mode under one flavor of scaling: none, moderate,
    // then the register extremes, then raw random patterns.
    for (int phase = 0; phase < 16; phase++) begin
      m = mode_t'(phase % 4);
      flavor = phase / 4;
      case (flavor)
        0: begin
          scale = F32_ONE;
          inv_scale = F32_ONE;
          zp = 32'd0;
        end
        1: begin
          scale = {1'($urandom_range(1)), 8'($urandom_range(110, 140)), 23'($urandom())};
          inv_scale = {1'($urandom_range(1)), 8'($urandom_range(110, 140)), 23'($urandom())};
          zp = 32'($urandom_range(40)) - 32'd20;
        end
        2: begin
          if (phase % 2 == 0) begin
            scale = 32'h7F7F_FFFF;
            inv_scale = 32'h0000_0001;
            zp = 32'h8000_0000;
          end else begin
            scale = 32'h0000_0000;
            inv_scale = 32'hFFFF_FFFF;
            zp = 32'h7FFF_FFFF;
          end
        end
        default: begin
          scale = $urandom();
          inv_scale = $urandom();
          zp = ($urandom_range(1) != 0) ? $urandom() : 32'($urandom_range(3));
        end
      endcase
      if (phase == 5) begin
        send_idle_pct = 77;
        recv_idle_pct = 35;
      end else if (phase == 11) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_config(m, scale, inv_scale, zp);
      for (int k = 0; k < 80; k++) begin
        if (phase == 12 && k == 5) pressure_req = 1'b1;
        send_item(rand_element(), 1'($urandom_range(1)));
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
